// ===== hw/rtl/cls_pkg.sv =====
// Shared types, constants and the microcode table of the character LCD nibble sequencer.
package cls_pkg;

  // Operation codes of a request
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_POS   = 2'd2;

  // Characters with special handling
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;

  // Command bytes and DDRAM row bases
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] ROW1_BASE  = 8'h80;
  localparam logic [7:0] ROW2_BASE  = 8'hC0;
  localparam logic [1:0] ROW_FIRST  = 2'd1;
  localparam logic [1:0] ROW_SECOND = 2'd2;

  // Phases of one nibble transfer
  localparam logic [1:0] PH_SET  = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;

  localparam logic [1:0] HOLD_SHORT = 2'd1;

  // Microcode layout
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ENTRY_INIT = 5'd0;
  localparam logic [STEP_W-1:0] ENTRY_BYTE = 5'd15;

  // Where a step takes its nibble (and select level) from
  typedef enum logic [1:0] {
    NSRC_HELD  = 2'd0,  // last driven pins, select from held state
    NSRC_CONST = 2'd1,  // nibble from the control word, command select
    NSRC_HI    = 2'd2,  // high nibble of the request byte
    NSRC_LO    = 2'd3   // low nibble of the request byte
  } nsrc_e;

  typedef struct packed {
    logic       single;  // one phase only, enable stays low
    nsrc_e      nsrc;
    logic [3:0] nib;
    logic [1:0] tail;    // hold of the final phase of the step
    logic       eop;     // final step of the program
  } ctl_t;

  function automatic ctl_t cls_rom(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{single: 1'b1, nsrc: NSRC_HELD, nib: 4'h0, tail: 2'd1, eop: 1'b1};
    case (step)
      5'd0:  w = '{1'b1, NSRC_HELD,  4'h0, 2'd1, 1'b0};  // settle wait
      5'd1:  w = '{1'b0, NSRC_CONST, 4'h3, 2'd3, 1'b0};  // raw wake-up nibbles
      5'd2:  w = '{1'b0, NSRC_CONST, 4'h3, 2'd2, 1'b0};
      5'd3:  w = '{1'b0, NSRC_CONST, 4'h3, 2'd2, 1'b0};
      5'd4:  w = '{1'b0, NSRC_CONST, 4'h2, 2'd2, 1'b0};  // switch to 4-bit
      5'd5:  w = '{1'b0, NSRC_CONST, 4'h2, 2'd2, 1'b0};  // function set
      5'd6:  w = '{1'b0, NSRC_CONST, 4'hF, 2'd2, 1'b0};
      5'd7:  w = '{1'b0, NSRC_CONST, 4'h0, 2'd2, 1'b0};  // display off
      5'd8:  w = '{1'b0, NSRC_CONST, 4'h8, 2'd2, 1'b0};
      5'd9:  w = '{1'b0, NSRC_CONST, 4'h0, 2'd2, 1'b0};  // clear
      5'd10: w = '{1'b0, NSRC_CONST, 4'h1, 2'd2, 1'b0};
      5'd11: w = '{1'b0, NSRC_CONST, 4'h0, 2'd2, 1'b0};  // entry mode
      5'd12: w = '{1'b0, NSRC_CONST, 4'h6, 2'd2, 1'b0};
      5'd13: w = '{1'b0, NSRC_CONST, 4'h0, 2'd2, 1'b0};  // display on
      5'd14: w = '{1'b0, NSRC_CONST, 4'hC, 2'd2, 1'b1};
      5'd15: w = '{1'b0, NSRC_HI,    4'h0, 2'd2, 1'b0};  // byte routine
      5'd16: w = '{1'b0, NSRC_LO,    4'h0, 2'd2, 1'b1};
      default: w = '{1'b1, NSRC_HELD, 4'h0, 2'd1, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer: request decode, microcode sequencer, pins.
//
// Turns requests for a 4-bit character LCD into a run of pin phases.
// Input channel (in_valid_i / in_stall_o) carries one request item: operation_i
// (init, write character, set position), char_code_i, column_i, row_i.
// Output channel (out_valid_o / out_stall_i) carries one item per pin phase:
// reg_select_o, data_nibble_o, enable_o, hold_units_o and last_o on the run's final phase.
// Each nibble is three phases (set pins, raise enable, lower enable); a byte is
// high nibble then low nibble. Init gives one wait phase, four raw nibbles and
// five command bytes: 43 phases. A character or position gives 6 phases.
// Newline, form feed, bad positions and the unused operation give nothing.
// Timing: the request is registered into the sequencer state, then each phase
// into the output register; the next request is taken in the cycle after the
// final phase is loaded. Rate is set by the microcode step and phase counters,
// which issue one phase per cycle while the receiver does not stall.
// A receiver stall freezes the output register and the sequencer.
// Reset empties the output, idles the sequencer and clears the held pin levels
// that the init wait phase drives.
module char_lcd_nibble_sequencer #(
  parameter int COLUMNS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] column_i,
  input  logic [1:0] row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       reg_select_o,
  output logic [3:0] data_nibble_o,
  output logic       enable_o,
  output logic [1:0] hold_units_o,
  output logic       last_o
);
  import cls_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        ph_q, ph_d;
  logic [7:0]        byte_q, byte_d;
  logic              rs_q, rs_d;
  logic              held_sel_q, held_sel_d;
  logic [3:0]        held_dat_q, held_dat_d;
  logic              out_valid_q, out_valid_d;
  logic              out_rs_q;
  logic [3:0]        out_nib_q;
  logic              out_en_q;
  logic [1:0]        out_hold_q;
  logic              out_last_q;

  logic              accept;
  logic              start_run;
  logic [STEP_W-1:0] start_step;
  logic [7:0]        req_byte;
  logic              req_rs;
  logic              pos_ok;
  logic [7:0]        pos_addr;

  ctl_t              cw;
  logic              load;
  logic              step_done;
  logic              ph_rs;
  logic [3:0]        ph_nib;
  logic              ph_en;
  logic [1:0]        ph_hold;
  logic              ph_last;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  // Request decode: pick the program entry and the byte to send
  assign pos_ok = (column_i != 5'd0) && (32'(column_i) <= 32'(COLUMNS)) &&
                  ((row_i == ROW_FIRST) || (row_i == ROW_SECOND));
  assign pos_addr = 8'(((row_i == ROW_FIRST) ? ROW1_BASE : ROW2_BASE) +
                       {3'b000, column_i} - 8'd1);

  always_comb begin
    start_run  = 1'b0;
    start_step = ENTRY_BYTE;
    req_byte   = char_code_i;
    req_rs     = 1'b1;
    case (operation_i)
      OP_INIT: begin
        start_run  = 1'b1;
        start_step = ENTRY_INIT;
      end
      OP_WRITE: begin
        if (char_code_i == CH_BACKSPACE) begin
          start_run = 1'b1;
          req_byte  = CMD_CLEAR;
          req_rs    = 1'b0;
        end else if ((char_code_i != CH_NEWLINE) && (char_code_i != CH_FORMFEED)) begin
          start_run = 1'b1;
        end
      end
      OP_POS: begin
        start_run = pos_ok;
        req_byte  = pos_addr;
        req_rs    = 1'b0;
      end
      default: start_run = 1'b0;
    endcase
  end

  // Phase generation from the current control word
  assign cw        = cls_rom(step_q);
  assign load      = busy_q && (!out_valid_q || !out_stall_i);
  assign step_done = cw.single || (ph_q == PH_FALL);
  assign ph_last   = step_done && cw.eop;
  assign ph_en     = !cw.single && (ph_q == PH_RISE);
  assign ph_hold   = step_done ? cw.tail : HOLD_SHORT;

  always_comb begin
    case (cw.nsrc)
      NSRC_HELD: begin
        ph_rs  = held_sel_q;
        ph_nib = held_dat_q;
      end
      NSRC_CONST: begin
        ph_rs  = 1'b0;
        ph_nib = cw.nib;
      end
      NSRC_HI: begin
        ph_rs  = rs_q;
        ph_nib = byte_q[7:4];
      end
      NSRC_LO: begin
        ph_rs  = rs_q;
        ph_nib = byte_q[3:0];
      end
      default: begin
        ph_rs  = held_sel_q;
        ph_nib = held_dat_q;
      end
    endcase
  end

  // Sequencer: advance phase, then step, drop busy after the final phase
  always_comb begin
    busy_d     = busy_q;
    step_d     = step_q;
    ph_d       = ph_q;
    byte_d     = byte_q;
    rs_d       = rs_q;
    held_sel_d = held_sel_q;
    held_dat_d = held_dat_q;
    if (accept && start_run) begin
      busy_d = 1'b1;
      step_d = start_step;
      ph_d   = PH_SET;
      byte_d = req_byte;
      rs_d   = req_rs;
    end else if (load) begin
      // every phase leaves its pins as the held levels
      held_sel_d = ph_rs;
      held_dat_d = ph_nib;
      if (step_done) begin
        ph_d = PH_SET;
        if (cw.eop) begin
          busy_d = 1'b0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end else begin
        ph_d = ph_q + 2'd1;
      end
    end
  end

  // Output register: load on a free slot, hold while stalled
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= ENTRY_INIT;
      ph_q        <= PH_SET;
      held_sel_q  <= 1'b0;
      held_dat_q  <= 4'h0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      ph_q        <= ph_d;
      held_sel_q  <= held_sel_d;
      held_dat_q  <= held_dat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rs_q   <= rs_d;
    if (load) begin
      out_rs_q   <= ph_rs;
      out_nib_q  <= ph_nib;
      out_en_q   <= ph_en;
      out_hold_q <= ph_hold;
      out_last_q <= ph_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reg_select_o  = out_rs_q;
  assign data_nibble_o = out_nib_q;
  assign enable_o      = out_en_q;
  assign hold_units_o  = out_hold_q;
  assign last_o        = out_last_q;

endmodule

// ===== hw/rtl/cls_checker.sv =====
// Port-level checks of the character LCD nibble sequencer and their binding.
module cls_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       reg_select_o,
  input logic [3:0] data_nibble_o,
  input logic       enable_o,
  input logic [1:0] hold_units_o,
  input logic       last_o
);

  // Hold a stalled phase unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({reg_select_o, data_nibble_o, enable_o, hold_units_o, last_o}))
    else $error("stalled phase changed");

  // A run still in progress blocks new requests
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("request taken in the middle of a run");

  // The enable strobe lasts one delay unit
  a_strobe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && enable_o |-> hold_units_o == 2'd1)
    else $error("enable phase held too long");

  // A run never ends with enable high
  a_end_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && enable_o |-> !last_o)
    else $error("run ended with enable high");

  // Every phase holds at least one unit
  a_hold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hold_units_o != 2'd0)
    else $error("zero hold");

endmodule

bind char_lcd_nibble_sequencer cls_checker u_cls_checker (.*);

// ===== verif/char_lcd_nibble_sequencer_tb.sv =====
// Self-checking testbench of the character LCD nibble sequencer: random requests, pin phase check.
module char_lcd_nibble_sequencer_tb;
  import cls_pkg::*;

  // Geometry of the display under test
  localparam int COLUMNS = 16;

  // Request and pin codes not named in the package
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic       RS_CMD    = 1'b0;
  localparam logic       RS_DATA   = 1'b1;

  // Init program: raw wake-up nibbles, then the command bytes
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;
  localparam logic [7:0] CMD_FUNC_SET = 8'h2F;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;

  // Hold of a nibble's closing phase
  localparam logic [1:0] HOLD_BYTE  = 2'd2;
  localparam logic [1:0] HOLD_FIRST = 2'd3;

  localparam int unsigned RANDOM_REQUESTS = 375;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned DRAIN_CYCLES    = 50;
  // Slowest correct run: ~450 requests x 43 phases, each behind the longest stall,
  // plus sender gaps. Allow several times that.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [4:0] col;
    logic [1:0] row;
  } lcd_request_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       en;
    logic [1:0] hold;
    logic       last;
  } lcd_phase_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] operation_i = OP_INIT;
  logic [7:0] char_code_i = 8'h00;
  logic [4:0] column_i = 5'd0;
  logic [1:0] row_i = 2'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       reg_select_o;
  logic [3:0] data_nibble_o;
  logic       enable_o;
  logic [1:0] hold_units_o;
  logic       last_o;

  // Requests waiting for the driver, and pin phases waiting for the monitor
  lcd_request_t request_backlog[$];
  lcd_phase_t   pending_phases[$];

  // Pin levels last driven, as the init wait phase repeats them
  logic       held_sel = RS_CMD;
  logic [3:0] held_dat = 4'h0;

  int unsigned  total_requests = 0;
  int unsigned  requests_taken = 0;
  int unsigned  phases_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  drv_gap = 0;
  int unsigned  stall_left = 0;
  int unsigned  stall_len;
  bit           drv_calm = 1'b0;
  bit           mon_calm = 1'b0;
  lcd_request_t next_req;
  lcd_phase_t   seen_phase;
  lcd_phase_t   want_phase;

  char_lcd_nibble_sequencer #(
    .COLUMNS(COLUMNS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reg_select_o (reg_select_o),
    .data_nibble_o(data_nibble_o),
    .enable_o     (enable_o),
    .hold_units_o (hold_units_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Phase predictor
  // ---------------------------------------------------------------------------
  task automatic add_phase(logic rs, logic [3:0] nib, logic en, logic [1:0] hold);
    pending_phases.push_back('{rs: rs, nib: nib, en: en, hold: hold, last: 1'b0});
  endtask

  // Set pins, raise enable, lower enable; remember the pins for a later wait phase.
  task automatic add_nibble(logic [3:0] nib, logic rs, logic [1:0] tail);
    add_phase(rs, nib, 1'b0, HOLD_SHORT);
    add_phase(rs, nib, 1'b1, HOLD_SHORT);
    add_phase(rs, nib, 1'b0, tail);
    held_sel = rs;
    held_dat = nib;
  endtask

  // High nibble first
  task automatic add_byte(logic [7:0] b, logic rs);
    add_nibble(b[7:4], rs, HOLD_BYTE);
    add_nibble(b[3:0], rs, HOLD_BYTE);
  endtask

  task automatic predict_pins(lcd_request_t req);
    int unsigned before_cnt;
    logic [7:0]  addr;
    before_cnt = pending_phases.size();
    case (req.op)
      OP_INIT: begin
        // Wait phase repeats the pins last driven, enable low
        add_phase(held_sel, held_dat, 1'b0, HOLD_SHORT);
        add_nibble(NIB_WAKE, RS_CMD, HOLD_FIRST);
        add_nibble(NIB_WAKE, RS_CMD, HOLD_BYTE);
        add_nibble(NIB_WAKE, RS_CMD, HOLD_BYTE);
        add_nibble(NIB_4BIT, RS_CMD, HOLD_BYTE);
        add_byte(CMD_FUNC_SET, RS_CMD);
        add_byte(CMD_DISP_OFF, RS_CMD);
        add_byte(CMD_CLEAR, RS_CMD);
        add_byte(CMD_ENTRY, RS_CMD);
        add_byte(CMD_DISP_ON, RS_CMD);
      end
      OP_WRITE: begin
        // Newline and form feed are dropped; backspace clears the screen
        if (req.ch == CH_BACKSPACE) begin
          add_byte(CMD_CLEAR, RS_CMD);
        end else if (req.ch != CH_NEWLINE && req.ch != CH_FORMFEED) begin
          add_byte(req.ch, RS_DATA);
        end
      end
      OP_POS: begin
        if (req.col >= 5'd1 && req.col <= 5'(COLUMNS) &&
            (req.row == ROW_FIRST || req.row == ROW_SECOND)) begin
          addr = ((req.row == ROW_FIRST) ? ROW1_BASE : ROW2_BASE) + 8'(req.col - 5'd1);
          add_byte(addr, RS_CMD);
        end
      end
      default: begin
      end
    endcase
    // Flag the closing phase of the run
    if (pending_phases.size() > before_cnt)
      pending_phases[pending_phases.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic queue_request(logic [1:0] op, logic [7:0] ch, logic [4:0] col,
                               logic [1:0] row);
    request_backlog.push_back('{op: op, ch: ch, col: col, row: row});
  endtask

  // A request that gives pin phases, with random content
  task automatic queue_good_request();
    int unsigned r;
    logic [7:0]  ch;
    r  = $urandom_range(0, 99);
    ch = 8'($urandom_range(0, 255));
    if (r < 10) begin
      queue_request(OP_INIT, ch, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
    end else if (r < 60) begin
      if (ch == CH_NEWLINE || ch == CH_FORMFEED || $urandom_range(0, 19) == 0)
        ch = CH_BACKSPACE;
      queue_request(OP_WRITE, ch, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
    end else begin
      queue_request(OP_POS, ch, 5'($urandom_range(1, COLUMNS)),
                    $urandom_range(0, 1) ? ROW_FIRST : ROW_SECOND);
    end
  endtask

  // A request that the block drops: unused op, ignored char or bad position
  task automatic queue_noise_request();
    logic [7:0] ch;
    logic [4:0] col;
    logic [1:0] row;
    ch  = 8'($urandom_range(0, 255));
    col = 5'($urandom_range(0, 31));
    row = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0: queue_request(OP_UNUSED, ch, col, row);
      1: queue_request(OP_WRITE, $urandom_range(0, 1) ? CH_NEWLINE : CH_FORMFEED, col, row);
      2: queue_request(OP_POS, ch, $urandom_range(0, 1) ? 5'd0 :
                       5'($urandom_range(COLUMNS + 1, 31)), row);
      default: queue_request(OP_POS, ch, col, $urandom_range(0, 1) ? 2'd0 : 2'd3);
    endcase
  endtask

  initial begin
    // Directed part: init from reset, then init after a data write so the
    // wait phase carries data select, every special character and the
    // corners of the position window.
    queue_request(OP_INIT, 8'h00, 5'd0, 2'd0);
    queue_request(OP_WRITE, 8'h41, 5'd0, 2'd0);
    queue_request(OP_INIT, 8'hFF, 5'd31, 2'd3);
    queue_request(OP_WRITE, 8'h00, 5'd31, 2'd3);
    queue_request(OP_WRITE, 8'hFF, 5'd0, 2'd0);
    queue_request(OP_WRITE, CH_BACKSPACE, 5'd1, 2'd1);
    queue_request(OP_WRITE, CH_NEWLINE, 5'd1, 2'd1);
    queue_request(OP_WRITE, CH_FORMFEED, 5'd1, 2'd1);
    queue_request(OP_POS, 8'h00, 5'd1, ROW_FIRST);
    queue_request(OP_POS, 8'h00, 5'(COLUMNS), ROW_FIRST);
    queue_request(OP_POS, 8'hFF, 5'd1, ROW_SECOND);
    queue_request(OP_POS, 8'hFF, 5'(COLUMNS), ROW_SECOND);
    queue_request(OP_POS, 8'h00, 5'd0, ROW_FIRST);
    queue_request(OP_POS, 8'h00, 5'(COLUMNS + 1), ROW_FIRST);
    queue_request(OP_POS, 8'h00, 5'd31, ROW_SECOND);
    queue_request(OP_POS, 8'h00, 5'd5, 2'd0);
    queue_request(OP_POS, 8'h00, 5'd5, 2'd3);
    queue_request(OP_UNUSED, 8'hFF, 5'd31, 2'd3);
    queue_request(OP_INIT, 8'h00, 5'd0, 2'd0);

    // Random part: mostly productive requests, with dropped ones mixed in
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      queue_good_request();
      if ($urandom_range(0, 99) < 15)
        queue_noise_request();
    end
    total_requests = request_backlog.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample on the falling edge so the counters are settled
    do @(negedge clk_i); while (requests_taken != total_requests);
    do @(negedge clk_i); while (pending_phases.size() != 0);
    // Watch for stray phases after the last run
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_phases.size() == 0)
      $display("[char_lcd_nibble_sequencer] OK");
    else
      $display("[char_lcd_nibble_sequencer] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request driver: predict on acceptance, then load the next item or idle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_gap    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_pins('{op: operation_i, ch: char_code_i, col: column_i, row: row_i});
        requests_taken++;
        // Switch now and then between idling and back-to-back stretches
        if ($urandom_range(0, 19) == 0)
          drv_calm = !drv_calm;
      end
      // Hold the payload while stalled; otherwise advance
      if (!in_valid_i || !in_stall_o) begin
        if (drv_gap != 0) begin
          in_valid_i <= 1'b0;
          drv_gap    <= drv_gap - 1;
        end else if (request_backlog.size() != 0) begin
          next_req = request_backlog.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= next_req.op;
          char_code_i <= next_req.ch;
          column_i    <= next_req.col;
          row_i       <= next_req.row;
          drv_gap     <= drv_calm ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Phase monitor: check each accepted phase, and stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_phase = '{rs: reg_select_o, nib: data_nibble_o, en: enable_o,
                       hold: hold_units_o, last: last_o};
        if (pending_phases.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("phase %0d not expected: rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                     phases_seen, seen_phase.rs, seen_phase.nib, seen_phase.en,
                     seen_phase.hold, seen_phase.last);
        end else begin
          want_phase = pending_phases.pop_front();
          if (seen_phase.rs !== want_phase.rs || seen_phase.nib !== want_phase.nib ||
              seen_phase.en !== want_phase.en || seen_phase.hold !== want_phase.hold ||
              seen_phase.last !== want_phase.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("phase %0d: expected rs=%0d nib=%h en=%0d hold=%0d last=%0d, %s",
                       phases_seen, want_phase.rs, want_phase.nib, want_phase.en,
                       want_phase.hold, want_phase.last,
                       $sformatf("got rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                 seen_phase.rs, seen_phase.nib, seen_phase.en,
                                 seen_phase.hold, seen_phase.last));
          end
        end
        phases_seen++;
      end

      // Finish a running stall, or draw a new one
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        stall_len = mon_calm ? 0 : pick_gap();
        out_stall_i <= (stall_len != 0);
        stall_left  <= (stall_len == 0) ? 0 : stall_len - 1;
      end
      if ($urandom_range(0, 99) == 0)
        mon_calm = !mon_calm;
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[char_lcd_nibble_sequencer] ERROR");
      $finish;
    end
  end

endmodule
